### design/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Shared sizes, the cell slot type and window length helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swm_pkg;

  localparam int WINDOW      = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int CFG_W       = 7;
  localparam int OUT_W       = SAMPLE_BITS + 1;
  localparam int LEN_W       = $clog2(WINDOW + 1);
  localparam int PTR_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CMP_W       = (CFG_W > LEN_W) ? CFG_W : LEN_W;

  // One position of the sorted window.
  typedef struct packed {
    logic                   vld;
    logic [SAMPLE_BITS-1:0] val;
  } slot_t;

  // Length zero acts as one; lengths beyond the storage saturate.
  function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] raw);
    logic [CMP_W-1:0] ext;
    logic [LEN_W-1:0] res;
    ext = CMP_W'(raw);
    if (ext == '0) begin
      res = LEN_W'(1);
    end else if (ext > CMP_W'(WINDOW)) begin
      res = LEN_W'(WINDOW);
    end else begin
      res = LEN_W'(ext);
    end
    return res;
  endfunction

  // One-hot mask that marks the cell holding sorted rank idx.
  function automatic logic [WINDOW-1:0] rank_sel(input logic [LEN_W-1:0] idx);
    logic [WINDOW-1:0] sel;
    for (int i = 0; i < WINDOW; i++) begin
      sel[i] = (LEN_W'(i) == idx);
    end
    return sel;
  endfunction

endpackage

### design/swm_in_if.sv
// ----------------------------------------------------------------------------
// Sample input channel
// Valid/ready channel carrying one unsigned sample per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swm_in_if;
  logic                           valid;
  logic                           ready;
  logic [swm_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

### design/swm_out_if.sv
// ----------------------------------------------------------------------------
// Median output channel
// Valid/ready channel carrying the doubled median per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swm_out_if;
  logic                     valid;
  logic                     ready;
  logic [swm_pkg::OUT_W-1:0] median_sum;

  modport source (output valid, output median_sum, input ready);
  modport sink (input valid, input median_sum, output ready);
endinterface

### design/swm_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the window length register value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [swm_pkg::CFG_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink (input valid, input window_len, output ready);
endinterface

### design/swm_cell.sv
// ----------------------------------------------------------------------------
// Sorted window cell
// One position of the sorted window. Removal and insertion are resolved
// from the neighbor values, so the whole row updates together on each sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            remove_i,
  input  logic                            clear_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] rm_val_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] ins_val_i,
  input  swm_pkg::slot_t                  right_i,
  input  swm_pkg::slot_t                  left_post_i,
  output swm_pkg::slot_t                  slot_o,
  output swm_pkg::slot_t                  post_o
);

  logic                            vld_q, vld_d;
  logic [swm_pkg::SAMPLE_BITS-1:0] val_q, val_d;
  swm_pkg::slot_t                  cur;
  swm_pkg::slot_t                  post;
  logic                            keep;

  assign cur.vld = vld_q;
  assign cur.val = val_q;

  // Cells below the removed value stay; from there on, each takes its right neighbor.
  assign keep = cur.vld && (cur.val < rm_val_i);

  always_comb begin
    if (!remove_i || keep) begin
      post = cur;
    end else begin
      post = right_i;
    end
  end

  // Insertion: keep a value not above the sample, take the left value if it
  // is above the sample, otherwise this is where the sample lands.
  always_comb begin
    if (post.vld && (post.val <= ins_val_i)) begin
      vld_d = 1'b1;
      val_d = post.val;
    end else if (left_post_i.vld && (left_post_i.val > ins_val_i)) begin
      vld_d = 1'b1;
      val_d = left_post_i.val;
    end else if (left_post_i.vld) begin
      vld_d = 1'b1;
      val_d = ins_val_i;
    end else begin
      vld_d = 1'b0;
      val_d = post.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (clear_i) begin
      vld_q <= 1'b0;
    end else if (step_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      val_q <= val_d;
    end
  end

  assign slot_o = cur;
  assign post_o = post;

endmodule

### design/swm_ring.sv
// ----------------------------------------------------------------------------
// Sample history ring
// Arrival-order store of the window. The oldest sample of the window is
// read ahead into a register so that it is ready for the next beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swm_ring (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic                            restart_i,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [swm_pkg::LEN_W-1:0]       len_d_i,
  output logic [swm_pkg::SAMPLE_BITS-1:0] oldest_o
);

  logic [swm_pkg::SAMPLE_BITS-1:0] mem [swm_pkg::WINDOW];
  logic [swm_pkg::PTR_W-1:0]       wr_pos_q, wr_pos_d;
  logic [swm_pkg::PTR_W-1:0]       rd_addr;
  logic [swm_pkg::LEN_W:0]         pos_ext;
  logic [swm_pkg::LEN_W:0]         len_ext;
  logic [swm_pkg::LEN_W:0]         diff;
  logic [swm_pkg::SAMPLE_BITS-1:0] oldest_q;

  always_comb begin
    wr_pos_d = wr_pos_q;
    if (restart_i) begin
      wr_pos_d = '0;
    end else if (push_i) begin
      if (wr_pos_q == swm_pkg::PTR_W'(swm_pkg::WINDOW - 1)) begin
        wr_pos_d = '0;
      end else begin
        wr_pos_d = wr_pos_q + swm_pkg::PTR_W'(1);
      end
    end
  end

  // Address of the sample that leaves the window on the next beat.
  always_comb begin
    pos_ext = (swm_pkg::LEN_W + 1)'(wr_pos_d);
    len_ext = (swm_pkg::LEN_W + 1)'(len_d_i);
    if (pos_ext >= len_ext) begin
      diff = pos_ext - len_ext;
    end else begin
      diff = pos_ext + (swm_pkg::LEN_W + 1)'(swm_pkg::WINDOW) - len_ext;
    end
    rd_addr = diff[swm_pkg::PTR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
    end else begin
      wr_pos_q <= wr_pos_d;
    end
  end

  // A sample written this beat that is also the next oldest is forwarded.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_pos_q] <= sample_i;
    end
    if (push_i && (wr_pos_q == rd_addr)) begin
      oldest_q <= sample_i;
    end else begin
      oldest_q <= mem[rd_addr];
    end
  end

  assign oldest_o = oldest_q;

endmodule

### design/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// Sliding window median filter
// Takes one sample per beat and, once the window holds window_len samples,
// returns the doubled median of the window for every further sample. The
// block accepts one sample per clock cycle unless a finished median waits
// for the output: a row of cells holds the window in sorted order and drops
// the oldest sample and inserts the new one in the same cycle, while the
// oldest sample is read ahead from the history ring. The median is registered.
// Writing window_len empties the window, so results resume once it has filled
// again. The write is taken at any time but is meant for an idle block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_median_top (
  input  logic clk_i,
  input  logic rst_ni,
  swm_in_if.sink    in_i,
  swm_out_if.source out_o,
  swm_cfg_if.sink   cfg_i
);

  localparam swm_pkg::slot_t EmptySlot  = '{vld: 1'b0, val: '0};
  localparam swm_pkg::slot_t BottomSlot = '{vld: 1'b1, val: '0};

  logic                            cfg_fire;
  logic                            in_fire;
  logic                            in_ready;
  logic                            full;
  logic                            produce;
  logic                            load;

  logic [swm_pkg::LEN_W-1:0]       len_q, len_d;
  logic [swm_pkg::LEN_W-1:0]       count_q, count_d;
  logic [swm_pkg::WINDOW-1:0]      sel_lo_q, sel_hi_q;
  logic                            pend_q, pend_d;
  logic                            out_valid_q, out_valid_d;
  logic [swm_pkg::OUT_W-1:0]       out_data_q;

  logic [swm_pkg::SAMPLE_BITS-1:0] oldest;
  logic [swm_pkg::SAMPLE_BITS-1:0] med_lo, med_hi;

  swm_pkg::slot_t                  cur  [swm_pkg::WINDOW];
  swm_pkg::slot_t                  post [swm_pkg::WINDOW];

  assign cfg_fire    = cfg_i.valid;
  assign cfg_i.ready = 1'b1;

  // The cells hold a finished window until its median has moved to the output.
  assign in_ready   = !pend_q || !out_valid_q || out_o.ready;
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;
  assign full       = (count_q == len_q);
  assign produce    = in_fire && (full || ((count_q + swm_pkg::LEN_W'(1)) == len_q));
  assign load       = pend_q && (!out_valid_q || out_o.ready);

  always_comb begin
    len_d = len_q;
    if (cfg_fire) begin
      len_d = swm_pkg::eff_len(cfg_i.window_len);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cfg_fire) begin
      count_d = '0;
    end else if (in_fire && !full) begin
      count_d = count_q + swm_pkg::LEN_W'(1);
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (produce) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= swm_pkg::LEN_W'(swm_pkg::WINDOW);
      sel_lo_q    <= swm_pkg::rank_sel(swm_pkg::LEN_W'((swm_pkg::WINDOW - 1) / 2));
      sel_hi_q    <= swm_pkg::rank_sel(swm_pkg::LEN_W'(swm_pkg::WINDOW / 2));
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        sel_lo_q <= swm_pkg::rank_sel((len_d - swm_pkg::LEN_W'(1)) >> 1);
        sel_hi_q <= swm_pkg::rank_sel(len_d >> 1);
      end
    end
  end

  swm_ring u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_fire),
    .restart_i (cfg_fire),
    .sample_i  (in_i.sample),
    .len_d_i   (len_d),
    .oldest_o  (oldest)
  );

  for (genvar i = 0; i < swm_pkg::WINDOW; i++) begin : g_cell
    swm_pkg::slot_t right;
    swm_pkg::slot_t left_post;

    if (i == swm_pkg::WINDOW - 1) begin : g_last
      assign right = EmptySlot;
    end else begin : g_mid
      assign right = cur[i+1];
    end

    if (i == 0) begin : g_first
      assign left_post = BottomSlot;
    end else begin : g_rest
      assign left_post = post[i-1];
    end

    swm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (in_fire),
      .remove_i    (full),
      .clear_i     (cfg_fire),
      .rm_val_i    (oldest),
      .ins_val_i   (in_i.sample),
      .right_i     (right),
      .left_post_i (left_post),
      .slot_o      (cur[i]),
      .post_o      (post[i])
    );
  end

  // The rank masks are one-hot, so an OR over the masked cells selects them.
  always_comb begin
    med_lo = '0;
    med_hi = '0;
    for (int i = 0; i < swm_pkg::WINDOW; i++) begin
      if (sel_lo_q[i]) begin
        med_lo = med_lo | cur[i].val;
      end
      if (sel_hi_q[i]) begin
        med_hi = med_hi | cur[i].val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= swm_pkg::OUT_W'(med_lo) + swm_pkg::OUT_W'(med_hi);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.median_sum = out_data_q;

endmodule
